// ===== hw/rtl/spa_pkg.sv =====
package spa_pkg;

   // defaults for the top-level parameters
   localparam int NUM_SLABS_DEF   = 16;
   localparam int MAX_PIECES_DEF  = 256;
   localparam int NUM_CLASSES_DEF = 6;

   // field and register widths
   localparam int OP_W        = 1;
   localparam int REQ_BYTES_W = 16;
   localparam int OFFSET_W    = 18;
   localparam int CLASS_W     = 15;
   localparam int PAGES_W     = 3;
   localparam int COUNT_W     = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;

   // geometry
   localparam int PAGE_SHIFT = 12;
   localparam int MIN_CLASS  = 64;
   localparam int MAX_PAGES  = 4;
   localparam logic [PAGES_W-1:0] PAGES_RST = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_RST = 5'd16;

   // bitmap word
   localparam int BMP_WORD_W = 32;
   localparam int BMP_BIT_W  = 5;

   // shared divider
   localparam int DIV_N_W   = 18;
   localparam int DIV_D_W   = 15;
   localparam int DIV_CNT_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_PAGES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_COUNT = 3'd1;
   localparam int                   CSR_CLASS_BASE = 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [REQ_BYTES_W-1:0] request_bytes;
      logic [OFFSET_W-1:0]    free_offset;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [OFFSET_W-1:0] piece_offset;
      logic                slab_released;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
      logic [DIV_D_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PICK,
      ST_NDIV,
      ST_SLAB_RD,
      ST_SLAB_CHK,
      ST_WORD_RD,
      ST_WORD_CHK,
      ST_CLAIM,
      ST_CLEAR,
      ST_MUL,
      ST_ADONE,
      ST_F_SDIV,
      ST_F_CLS_RD,
      ST_F_CLS_CHK,
      ST_F_PDIV,
      ST_F_NDIV,
      ST_F_BIT_RD,
      ST_F_BIT_WR,
      ST_F_SCAN_RD,
      ST_F_SCAN_CHK,
      ST_F_REL
   } state_type;

   // lowest set bit of a bitmap word
   function automatic logic [BMP_BIT_W-1:0] first_set(input logic [BMP_WORD_W-1:0] v);
      logic [BMP_BIT_W-1:0] idx;
      idx = '0;
      for (int b = BMP_WORD_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            idx = BMP_BIT_W'(b);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hw/rtl/spa_divider.sv =====
// restoring divider, one quotient bit per cycle
module spa_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  spa_pkg::div_req_type div_req,
   output spa_pkg::div_rsp_type div_rsp
);

   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [spa_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [spa_pkg::DIV_N_W-1:0]     quo_ff, quo_in;
   logic [spa_pkg::DIV_D_W-1:0]     rem_ff, rem_in;
   logic [spa_pkg::DIV_D_W-1:0]     dvs_ff, dvs_in;
   logic [spa_pkg::DIV_D_W:0]       trial;
   logic                            ge;

   assign trial = {rem_ff, quo_ff[spa_pkg::DIV_N_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = spa_pkg::DIV_CNT_W'(spa_pkg::DIV_N_W);
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[spa_pkg::DIV_N_W-2:0], ge};
         rem_in = ge ? spa_pkg::DIV_D_W'(trial - {1'b0, dvs_ff})
                     : trial[spa_pkg::DIV_D_W-1:0];
         cnt_in = cnt_ff - spa_pkg::DIV_CNT_W'(1);
         if (cnt_ff == spa_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/spa_bitmap.sv =====
// piece-used bitmap, one 32-bit word per address, single port
module spa_bitmap #(
   parameter int ADDR_W = 4
) (
   input  logic                           clock,
   input  logic [ADDR_W-1:0]              addr,
   input  logic                           we,
   input  logic [spa_pkg::BMP_WORD_W-1:0] wdata,
   output logic [spa_pkg::BMP_WORD_W-1:0] rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [spa_pkg::BMP_WORD_W-1:0] mem [DEPTH];
   logic [spa_pkg::BMP_WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/spa_slab_table.sv =====
// class bound to each slab; an entry without its valid bit reads as unassigned
module spa_slab_table #(
   parameter int NUM_SLABS = spa_pkg::NUM_SLABS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [SLAB_W-1:0]           rd_addr,
   output logic [spa_pkg::CLASS_W-1:0] rd_class,
   input  logic                        wr_en,
   input  logic [SLAB_W-1:0]           wr_addr,
   input  logic [spa_pkg::CLASS_W-1:0] wr_class
);

   localparam int SLAB_W = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;

   logic [spa_pkg::CLASS_W-1:0] mem [NUM_SLABS];
   logic [NUM_SLABS-1:0]        valid_ff;
   logic [spa_pkg::CLASS_W-1:0] rd_class_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= (wr_class != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_class;
      end
      rd_class_ff <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_class = rd_valid_ff ? rd_class_ff : '0;

endmodule

// ===== hw/rtl/slab_piece_allocator.sv =====
// Sequence: alloc tries each class in turn (a divide, then a scan of the slabs and of the
//   bitmap words of slabs of that class, or a claim and clear of an unassigned slab); free
//   does three divides, then scans the bitmap words of the slab. One request at a time.
// Rate is set by the shared divider and the single-port bitmap memory.
// Result: one cycle rsp_strobe pulse in the same cycle that busy drops; receiver cannot stall.
// Reset: synchronous; all slabs unassigned, registers to defaults, no clearing pass.
module slab_piece_allocator #(
   parameter int NUM_SLABS   = spa_pkg::NUM_SLABS_DEF,
   parameter int MAX_PIECES  = spa_pkg::MAX_PIECES_DEF,
   parameter int NUM_CLASSES = spa_pkg::NUM_CLASSES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   input  spa_pkg::req_type               req_data,
   output logic                           busy,
   // result channel
   output logic                           rsp_strobe,
   output spa_pkg::rsp_type               rsp_data,
   // register write port
   input  logic                           csr_we,
   input  logic [spa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // slab index, slab counter (can hold the count itself)
   localparam int SLAB_W  = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int SCNT_W  = $clog2(NUM_SLABS + 1);
   // bitmap words per slab
   localparam int WORDS   = (MAX_PIECES + spa_pkg::BMP_WORD_W - 1) / spa_pkg::BMP_WORD_W;
   localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCNT_W  = $clog2(WORDS + 1);
   // piece count and piece index
   localparam int CNT_W   = $clog2(MAX_PIECES + 1);
   localparam int PIX_W   = WIDX_W + spa_pkg::BMP_BIT_W;
   localparam int CMP_W   = WCNT_W + spa_pkg::BMP_BIT_W + CNT_W;
   localparam int BMP_ADDR_W = SLAB_W + WIDX_W;
   localparam int BASE_W  = SCNT_W + spa_pkg::PAGES_W;
   localparam int PROD_W  = PIX_W + spa_pkg::CLASS_W;
   localparam int CLASS_W = spa_pkg::CLASS_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [spa_pkg::PAGES_W-1:0] cfg_pages_ff;
   logic [spa_pkg::COUNT_W-1:0] cfg_count_ff;
   logic [CLASS_W-1:0]          cfg_class_ff [NUM_CLASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pages_ff <= spa_pkg::PAGES_RST;
         cfg_count_ff <= spa_pkg::COUNT_RST;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cfg_class_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == spa_pkg::CSR_SLAB_PAGES) begin
            cfg_pages_ff <= csr_wdata[spa_pkg::PAGES_W-1:0];
         end
         if (csr_index == spa_pkg::CSR_SLAB_COUNT) begin
            cfg_count_ff <= csr_wdata[spa_pkg::COUNT_W-1:0];
         end
         for (int k = 0; k < NUM_CLASSES; k++) begin
            if (csr_index == spa_pkg::CSR_IDX_W'(spa_pkg::CSR_CLASS_BASE + k)) begin
               cfg_class_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // Saturated page count (1..4) and slab count (1..NUM_SLABS)
   logic [spa_pkg::PAGES_W-1:0] eff_pages;
   logic [SCNT_W-1:0]           eff_count;
   logic [CLASS_W-1:0]          slab_bytes;

   always_comb begin
      if (cfg_pages_ff == '0) begin
         eff_pages = spa_pkg::PAGES_W'(1);
      end else if (cfg_pages_ff > spa_pkg::PAGES_W'(spa_pkg::MAX_PAGES)) begin
         eff_pages = spa_pkg::PAGES_W'(spa_pkg::MAX_PAGES);
      end else begin
         eff_pages = cfg_pages_ff;
      end
      if (cfg_count_ff == '0) begin
         eff_count = SCNT_W'(1);
      end else if (32'(cfg_count_ff) > NUM_SLABS) begin
         eff_count = SCNT_W'(NUM_SLABS);
      end else begin
         eff_count = SCNT_W'(cfg_count_ff);
      end
   end

   // pages * 4096
   assign slab_bytes = {eff_pages, {spa_pkg::PAGE_SHIFT{1'b0}}};

   // ------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------
   spa_pkg::state_type state_ff, state_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   spa_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                free_found_ff, free_found_in;

   logic [spa_pkg::REQ_BYTES_W-1:0] req_bytes_ff, req_bytes_in;
   logic [CLASS_W-1:0]              prev_ff, prev_in;   // last class tried
   logic [CLASS_W-1:0]              fit_ff, fit_in;     // class in work
   logic [CNT_W-1:0]                n_ff, n_in;         // pieces per slab
   logic [SCNT_W-1:0]               s_ff, s_in;         // slab pointer
   logic [WCNT_W-1:0]               w_ff, w_in;         // bitmap word pointer
   logic [SLAB_W-1:0]               free_s_ff, free_s_in;
   logic [PIX_W-1:0]                j_ff, j_in;         // piece index
   logic [spa_pkg::DIV_D_W-1:0]     rem_ff, rem_in;     // offset inside slab
   logic [spa_pkg::DIV_N_W-1:0]     p_ff, p_in;         // piece of a free
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic [BASE_W-1:0]               base_ff, base_in;

   // ------------------------------------------------------------------
   // Shared divider, bitmap memory, slab class table
   // ------------------------------------------------------------------
   spa_pkg::div_req_type div_req;
   spa_pkg::div_rsp_type div_rsp;

   spa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [BMP_ADDR_W-1:0]          bmp_addr;
   logic                           bmp_we;
   logic [spa_pkg::BMP_WORD_W-1:0] bmp_wdata;
   logic [spa_pkg::BMP_WORD_W-1:0] bmp_rdata;

   spa_bitmap #(
      .ADDR_W (BMP_ADDR_W)
   ) u_bitmap (
      .clock (clock),
      .addr  (bmp_addr),
      .we    (bmp_we),
      .wdata (bmp_wdata),
      .rdata (bmp_rdata)
   );

   logic [CLASS_W-1:0] tbl_rd_class;
   logic               tbl_wr_en;
   logic [SLAB_W-1:0]  tbl_wr_addr;
   logic [CLASS_W-1:0] tbl_wr_class;

   spa_slab_table #(
      .NUM_SLABS (NUM_SLABS)
   ) u_slab_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (s_ff[SLAB_W-1:0]),
      .rd_class (tbl_rd_class),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_class (tbl_wr_class)
   );

   // ------------------------------------------------------------------
   // Class pick: smallest usable class >= request and above the last one tried.
   // Equal classes collapse because of the strict compare with prev.
   // ------------------------------------------------------------------
   logic               fit_any;
   logic [CLASS_W-1:0] fit_sel;

   always_comb begin
      fit_any = 1'b0;
      fit_sel = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         if (cfg_class_ff[k] >= CLASS_W'(spa_pkg::MIN_CLASS) &&
             cfg_class_ff[k] <= slab_bytes &&
             {1'b0, cfg_class_ff[k]} >= req_bytes_ff &&
             cfg_class_ff[k] > prev_ff &&
             (!fit_any || cfg_class_ff[k] < fit_sel)) begin
            fit_sel = cfg_class_ff[k];
            fit_any = 1'b1;
         end
      end
   end

   // pieces per slab from the divider quotient, capped at MAX_PIECES
   logic [CNT_W-1:0] n_cap;
   assign n_cap = (div_rsp.quotient > spa_pkg::DIV_N_W'(MAX_PIECES)) ?
                  CNT_W'(MAX_PIECES) : div_rsp.quotient[CNT_W-1:0];

   // live pieces of the current word: bits past the piece count don't count
   logic [spa_pkg::BMP_WORD_W-1:0] word_mask;
   logic [spa_pkg::BMP_WORD_W-1:0] free_bits;
   logic [spa_pkg::BMP_BIT_W-1:0]  free_idx;
   logic                           word_live;

   always_comb begin
      for (int b = 0; b < spa_pkg::BMP_WORD_W; b++) begin
         word_mask[b] = (CMP_W'({w_ff[WIDX_W-1:0], spa_pkg::BMP_BIT_W'(b)}) < CMP_W'(n_ff));
      end
   end

   assign free_bits = ~bmp_rdata & word_mask;
   assign free_idx  = spa_pkg::first_set(free_bits);
   assign word_live = (CMP_W'({w_ff, {spa_pkg::BMP_BIT_W{1'b0}}}) < CMP_W'(n_ff));

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      free_found_in = free_found_ff;
      req_bytes_in  = req_bytes_ff;
      prev_in       = prev_ff;
      fit_in        = fit_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      w_in          = w_ff;
      free_s_in     = free_s_ff;
      j_in          = j_ff;
      rem_in        = rem_ff;
      p_in          = p_ff;
      prod_in       = prod_ff;
      base_in       = base_ff;

      div_req       = '0;
      bmp_we        = 1'b0;
      bmp_wdata     = bmp_rdata;
      bmp_addr      = {s_ff[SLAB_W-1:0], w_ff[WIDX_W-1:0]};
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = s_ff[SLAB_W-1:0];
      tbl_wr_class  = '0;

      unique case (state_ff)
         spa_pkg::ST_IDLE: begin
            if (start) begin
               req_bytes_in = req_data.request_bytes;
               prev_in      = '0;
               if (req_data.op == spa_pkg::OP_ALLOC) begin
                  state_in = spa_pkg::ST_PICK;
               end else begin
                  // slab = offset / slab size
                  div_req.start    = 1'b1;
                  div_req.dividend = req_data.free_offset;
                  div_req.divisor  = slab_bytes;
                  state_in         = spa_pkg::ST_F_SDIV;
               end
            end
         end

         // ---------------- allocation ----------------
         spa_pkg::ST_PICK: begin
            if (!fit_any) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               state_in      = spa_pkg::ST_IDLE;
            end else begin
               fit_in           = fit_sel;
               div_req.start    = 1'b1;
               div_req.dividend = spa_pkg::DIV_N_W'(slab_bytes);
               div_req.divisor  = fit_sel;
               state_in         = spa_pkg::ST_NDIV;
            end
         end

         spa_pkg::ST_NDIV: begin
            if (div_rsp.done) begin
               n_in          = n_cap;
               s_in          = '0;
               free_found_in = 1'b0;
               state_in      = spa_pkg::ST_SLAB_RD;
            end
         end

         spa_pkg::ST_SLAB_RD: begin
            if (s_ff >= eff_count) begin
               state_in = spa_pkg::ST_CLAIM;
            end else begin
               state_in = spa_pkg::ST_SLAB_CHK;
            end
         end

         spa_pkg::ST_SLAB_CHK: begin
            if (tbl_rd_class == fit_ff) begin
               w_in     = '0;
               state_in = spa_pkg::ST_WORD_RD;
            end else begin
               // remember the lowest unassigned slab for a later claim
               if (tbl_rd_class == '0 && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_s_in     = s_ff[SLAB_W-1:0];
               end
               s_in     = s_ff + SCNT_W'(1);
               state_in = spa_pkg::ST_SLAB_RD;
            end
         end

         spa_pkg::ST_WORD_RD: begin
            if (!word_live) begin
               s_in     = s_ff + SCNT_W'(1);
               state_in = spa_pkg::ST_SLAB_RD;
            end else begin
               state_in = spa_pkg::ST_WORD_CHK;
            end
         end

         spa_pkg::ST_WORD_CHK: begin
            if (free_bits != '0) begin
               bmp_we    = 1'b1;
               bmp_wdata = bmp_rdata | (spa_pkg::BMP_WORD_W'(1) << free_idx);
               j_in      = {w_ff[WIDX_W-1:0], free_idx};
               state_in  = spa_pkg::ST_MUL;
            end else begin
               w_in     = w_ff + WCNT_W'(1);
               state_in = spa_pkg::ST_WORD_RD;
            end
         end

         spa_pkg::ST_CLAIM: begin
            if (!free_found_ff) begin
               // class exhausted, try the next larger one
               prev_in  = fit_ff;
               state_in = spa_pkg::ST_PICK;
            end else begin
               tbl_wr_en    = 1'b1;
               tbl_wr_addr  = free_s_ff;
               tbl_wr_class = fit_ff;
               s_in         = SCNT_W'(free_s_ff);
               w_in         = '0;
               j_in         = '0;
               state_in     = spa_pkg::ST_CLEAR;
            end
         end

         // wipe the claimed slab's bitmap, piece 0 taken
         spa_pkg::ST_CLEAR: begin
            bmp_we    = 1'b1;
            bmp_wdata = (w_ff == '0) ? spa_pkg::BMP_WORD_W'(1) : '0;
            w_in      = w_ff + WCNT_W'(1);
            if (w_ff == WCNT_W'(WORDS - 1)) begin
               state_in = spa_pkg::ST_MUL;
            end
         end

         spa_pkg::ST_MUL: begin
            prod_in  = j_ff * fit_ff;
            base_in  = s_ff * eff_pages;
            state_in = spa_pkg::ST_ADONE;
         end

         spa_pkg::ST_ADONE: begin
            rsp_strobe_in              = 1'b1;
            rsp_data_in.ok             = 1'b1;
            rsp_data_in.piece_offset   =
               spa_pkg::OFFSET_W'({base_ff, {spa_pkg::PAGE_SHIFT{1'b0}}}) +
               spa_pkg::OFFSET_W'(prod_ff);
            rsp_data_in.slab_released  = 1'b0;
            state_in                   = spa_pkg::ST_IDLE;
         end

         // ---------------- free ----------------
         spa_pkg::ST_F_SDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= spa_pkg::DIV_N_W'(eff_count)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = spa_pkg::ST_IDLE;
               end else begin
                  s_in     = SCNT_W'(div_rsp.quotient);
                  rem_in   = div_rsp.remainder;
                  state_in = spa_pkg::ST_F_CLS_RD;
               end
            end
         end

         spa_pkg::ST_F_CLS_RD: begin
            state_in = spa_pkg::ST_F_CLS_CHK;
         end

         spa_pkg::ST_F_CLS_CHK: begin
            if (tbl_rd_class == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               state_in      = spa_pkg::ST_IDLE;
            end else begin
               fit_in           = tbl_rd_class;
               div_req.start    = 1'b1;
               div_req.dividend = spa_pkg::DIV_N_W'(rem_ff);
               div_req.divisor  = tbl_rd_class;
               state_in         = spa_pkg::ST_F_PDIV;
            end
         end

         spa_pkg::ST_F_PDIV: begin
            if (div_rsp.done) begin
               p_in             = div_rsp.quotient;
               div_req.start    = 1'b1;
               div_req.dividend = spa_pkg::DIV_N_W'(slab_bytes);
               div_req.divisor  = fit_ff;
               state_in         = spa_pkg::ST_F_NDIV;
            end
         end

         spa_pkg::ST_F_NDIV: begin
            if (div_rsp.done) begin
               n_in = n_cap;
               // piece past the last whole piece of the slab
               if (p_ff >= spa_pkg::DIV_N_W'(n_cap)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  state_in      = spa_pkg::ST_IDLE;
               end else begin
                  j_in     = p_ff[PIX_W-1:0];
                  state_in = spa_pkg::ST_F_BIT_RD;
               end
            end
         end

         spa_pkg::ST_F_BIT_RD: begin
            bmp_addr = {s_ff[SLAB_W-1:0], j_ff[PIX_W-1:spa_pkg::BMP_BIT_W]};
            state_in = spa_pkg::ST_F_BIT_WR;
         end

         spa_pkg::ST_F_BIT_WR: begin
            bmp_addr  = {s_ff[SLAB_W-1:0], j_ff[PIX_W-1:spa_pkg::BMP_BIT_W]};
            bmp_we    = 1'b1;
            bmp_wdata = bmp_rdata &
                        ~(spa_pkg::BMP_WORD_W'(1) << j_ff[spa_pkg::BMP_BIT_W-1:0]);
            w_in      = '0;
            state_in  = spa_pkg::ST_F_SCAN_RD;
         end

         // any live piece left in the slab?
         spa_pkg::ST_F_SCAN_RD: begin
            if (!word_live) begin
               state_in = spa_pkg::ST_F_REL;
            end else begin
               state_in = spa_pkg::ST_F_SCAN_CHK;
            end
         end

         spa_pkg::ST_F_SCAN_CHK: begin
            if ((bmp_rdata & word_mask) != '0) begin
               rsp_strobe_in             = 1'b1;
               rsp_data_in.ok            = 1'b1;
               rsp_data_in.piece_offset  = '0;
               rsp_data_in.slab_released = 1'b0;
               state_in                  = spa_pkg::ST_IDLE;
            end else begin
               w_in     = w_ff + WCNT_W'(1);
               state_in = spa_pkg::ST_F_SCAN_RD;
            end
         end

         spa_pkg::ST_F_REL: begin
            tbl_wr_en                 = 1'b1;
            tbl_wr_class              = '0;
            rsp_strobe_in             = 1'b1;
            rsp_data_in.ok            = 1'b1;
            rsp_data_in.piece_offset  = '0;
            rsp_data_in.slab_released = 1'b1;
            state_in                  = spa_pkg::ST_IDLE;
         end

         default: begin
            state_in = spa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spa_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      req_bytes_ff <= req_bytes_in;
      prev_ff      <= prev_in;
      fit_ff       <= fit_in;
      n_ff         <= n_in;
      s_ff         <= s_in;
      w_ff         <= w_in;
      free_s_ff    <= free_s_in;
      j_ff         <= j_in;
      rem_ff       <= rem_in;
      p_ff         <= p_in;
      prod_ff      <= prod_in;
      base_ff      <= base_in;
   end

   assign busy       = (state_ff != spa_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
